>>> hw/rtl/i2cws_pkg.sv
// ----------------------------------------------------------------------------
// i2cws_pkg
// Shared types, codes and sequence tables of the I2C master write sequencer.
// ----------------------------------------------------------------------------
package i2cws_pkg;

   // command codes of the request channel
   localparam logic [3:0] OP_TICK  = 4'd0;
   localparam logic [3:0] OP_RESET = 4'd8;

   // configuration register indexes
   localparam logic CSR_PHASE_TICKS   = 1'b0;
   localparam logic CSR_RESET_PRESENT = 1'b1;

   localparam logic [9:0] PHASE_TICKS_RESET = 10'd10;

   // running sequence, equal to the low bits of the opcode that started it
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_START   = 3'd2,
      CMD_SEND    = 3'd3,
      CMD_STOP    = 3'd4,
      CMD_PROBE   = 3'd5,
      CMD_CLOCK   = 3'd6,
      CMD_DATA    = 3'd7
   } cmd_type;

   // pin action: bit 1 picks the line (0 clock, 1 data), bit 0 the level
   localparam logic [2:0] ACT_CLK_LOW  = 3'd0;
   localparam logic [2:0] ACT_CLK_HIGH = 3'd1;
   localparam logic [2:0] ACT_DAT_LOW  = 3'd2;
   localparam logic [2:0] ACT_DAT_HIGH = 3'd3;
   localparam logic [2:0] ACT_END      = 3'd4;

   // bit phases of a byte plus the acknowledge slot
   localparam logic [5:0] BIT_PHASES   = 6'd24;
   localparam logic [5:0] ACK_LOW_J    = 6'd26;
   localparam logic [5:0] PROBE_PREFIX = 6'd6;
   localparam logic [5:0] START_PREFIX = 6'd4;
   localparam logic [5:0] ACK_SAMPLE_IDX = PROBE_PREFIX + ACK_LOW_J;

   typedef struct packed {
      cmd_type    cmd;
      logic [5:0] phase;
      logic [9:0] hold;
      logic [7:0] shift;
      logic       clk_drv;
      logic       dat_drv;
      logic       rst_drv;
      logic       ack_seen;
      logic       level;
   } seq_state_type;

   typedef struct packed {
      logic rejected;
      logic probe_ack;
      logic probe_done;
      logic busy;
      logic reset_level;
      logic sda_level;
      logic scl_level;
   } seq_result_type;

   // remainder by three of a six bit value below 63
   function automatic logic [1:0] mod3_f(input logic [5:0] v);
      logic [3:0] s;
      s = '0;
      for (int i = 0; i < 6; i++) begin
         if ((i & 1) == 0) s = s + {3'd0, v[i]};
         else s = s + {2'd0, v[i], 1'b0};
      end
      if (s >= 4'd6) s = s - 4'd6;
      else if (s >= 4'd3) s = s - 4'd3;
      return s[1:0];
   endfunction

   function automatic logic [5:0] prefix_f(input cmd_type cmd);
      logic [5:0] p;
      case (cmd)
         CMD_START: p = START_PREFIX;
         CMD_PROBE: p = PROBE_PREFIX;
         default:   p = '0;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] stop_f(input logic [1:0] k);
      logic [2:0] a;
      case (k)
         2'd0:    a = ACT_DAT_LOW;
         2'd1:    a = ACT_CLK_HIGH;
         2'd2:    a = ACT_DAT_HIGH;
         default: a = ACT_END;
      endcase
      return a;
   endfunction

   function automatic logic is_byte_cmd_f(input cmd_type cmd);
      return cmd == CMD_START || cmd == CMD_SEND || cmd == CMD_PROBE;
   endfunction

   // pin action of step idx of a sequence
   function automatic logic [2:0] action_f(input cmd_type cmd, input logic [5:0] idx,
                                           input logic msb, input logic level);
      logic [5:0] pre;
      logic [5:0] j;
      logic [2:0] a;
      a   = ACT_END;
      pre = prefix_f(cmd);
      j   = idx - pre;
      case (cmd)
         CMD_RELEASE: begin
            if (idx == 6'd0) a = ACT_CLK_HIGH;
            else if (idx == 6'd1) a = ACT_DAT_HIGH;
         end
         CMD_STOP: begin
            if (idx < 6'd3) a = stop_f(idx[1:0]);
         end
         CMD_CLOCK: begin
            if (idx == 6'd0) a = {2'b00, level};
         end
         CMD_DATA: begin
            if (idx == 6'd0) a = {2'b01, level};
         end
         CMD_START, CMD_SEND, CMD_PROBE: begin
            if (idx < pre) begin
               if (cmd == CMD_START) begin
                  // data high, clock high, data low, clock low
                  case (idx[1:0])
                     2'd0:    a = ACT_DAT_HIGH;
                     2'd1:    a = ACT_CLK_HIGH;
                     2'd2:    a = ACT_DAT_LOW;
                     default: a = ACT_CLK_LOW;
                  endcase
               end else begin
                  case (idx[2:0])
                     3'd0:    a = ACT_CLK_HIGH;
                     3'd1:    a = ACT_DAT_HIGH;
                     3'd2:    a = ACT_DAT_HIGH;
                     3'd3:    a = ACT_CLK_HIGH;
                     3'd4:    a = ACT_DAT_LOW;
                     default: a = ACT_CLK_LOW;
                  endcase
               end
            end else if (j < BIT_PHASES) begin
               case (mod3_f(j))
                  2'd0:    a = {2'b01, msb};
                  2'd1:    a = ACT_CLK_HIGH;
                  default: a = ACT_CLK_LOW;
               endcase
            end else if (j == BIT_PHASES) begin
               a = ACT_DAT_HIGH;
            end else if (j == BIT_PHASES + 6'd1) begin
               a = ACT_CLK_HIGH;
            end else if (j == ACK_LOW_J) begin
               a = ACT_CLK_LOW;
            end else if (cmd == CMD_PROBE && j < ACK_LOW_J + 6'd4) begin
               a = stop_f(2'(j - ACK_LOW_J - 6'd1));
            end
         end
         default: a = ACT_END;
      endcase
      return a;
   endfunction

   // apply one pin change, shift the data byte on a bit's clock low, and restart the hold
   function automatic seq_state_type apply_f(input seq_state_type s, input cmd_type cmd,
                                             input logic [5:0] idx, input logic [2:0] act,
                                             input logic [9:0] ticks);
      seq_state_type r;
      logic [5:0]    pre;
      logic [5:0]    j;
      r   = s;
      pre = prefix_f(cmd);
      j   = idx - pre;
      if (act[1]) r.dat_drv = act[0];
      else r.clk_drv = act[0];
      if (is_byte_cmd_f(cmd) && idx >= pre && j < BIT_PHASES && mod3_f(j) == 2'd2) begin
         r.shift = {s.shift[6:0], 1'b0};
      end
      r.phase = idx;
      r.hold  = ticks;
      return r;
   endfunction

endpackage

>>> hw/rtl/i2c_master_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer_unit
// Write-only I2C master pin sequencer advanced by one transaction per tick.
// ----------------------------------------------------------------------------
// Each request transaction is one timer tick carrying a command (req_tuser)
// and its operand and the sampled data line (req_tdata). Each tick gives one
// response transaction with the clock, data and reset pin levels and status
// flags (busy, probe done, probe acknowledge, rejected).
// A request passes through an input register, then the sequencer step and
// the response register. One transaction is taken every cycle while the
// response side takes them; the rate is set by the single step between those registers.
// When the response side stalls, one more request is held in the input
// register, after which req_tready drops until the response is taken.
// Configuration is a plain write port: index 0 phase_ticks, index 1
// reset_present; write it only while no transaction is in flight.
// Reset empties both registers, releases the clock and data lines, drives
// reset high, clears the sequence and sets phase_ticks to 10.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer_unit
   import i2cws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], sda_sample[8], zero fill
   input  logic [3:0]  req_tuser,   // opcode[3:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // scl_level, sda_level, reset_level, busy_res,
                                    // probe_done, probe_ack, rejected, zero fill
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [9:0]  csr_wdata
);

   logic           in_valid_ff, in_valid_in;
   logic [3:0]     op_ff;
   logic [7:0]     db_ff;
   logic           sda_ff;
   logic           out_valid_ff, out_valid_in;
   seq_result_type out_ff;
   seq_state_type  state_ff, state_in;
   seq_result_type step_res;
   logic [9:0]     phase_ticks_ff;
   logic           reset_present_ff;
   logic [9:0]     ticks_eff;
   logic           advance;
   logic           req_accept;

   // handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_tuser;
         db_ff  <= req_tdata[7:0];
         sda_ff <= req_tdata[8];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff    <= PHASE_TICKS_RESET;
         reset_present_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PHASE_TICKS:   phase_ticks_ff   <= csr_wdata;
            CSR_RESET_PRESENT: reset_present_ff <= csr_wdata[0];
            default:           phase_ticks_ff   <= phase_ticks_ff;
         endcase
      end
   end

   // zero hold is treated as one tick
   assign ticks_eff = (phase_ticks_ff == 10'd0) ? 10'd1 : phase_ticks_ff;

   i2cws_step u_step (
      .state_cur     (state_ff),
      .opcode        (op_ff),
      .data_byte     (db_ff),
      .sda_sample    (sda_ff),
      .ticks         (ticks_eff),
      .reset_present (reset_present_ff),
      .state_nxt     (state_in),
      .result        (step_res)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cmd      <= CMD_NONE;
         state_ff.phase    <= '0;
         state_ff.hold     <= '0;
         state_ff.shift    <= '0;
         state_ff.clk_drv  <= 1'b1;
         state_ff.dat_drv  <= 1'b1;
         state_ff.rst_drv  <= 1'b1;
         state_ff.ack_seen <= 1'b0;
         state_ff.level    <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) out_ff <= step_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.rejected, out_ff.probe_ack, out_ff.probe_done,
                        out_ff.busy, out_ff.reset_level, out_ff.sda_level,
                        out_ff.scl_level};

endmodule

>>> hw/rtl/i2cws_step.sv
// ----------------------------------------------------------------------------
// i2cws_step
// One tick of the pin sequencer: advance the running sequence, then decode
// the command of this transaction.
// ----------------------------------------------------------------------------
module i2cws_step
   import i2cws_pkg::*;
(
   input  seq_state_type  state_cur,
   input  logic [3:0]     opcode,
   input  logic [7:0]     data_byte,
   input  logic           sda_sample,
   input  logic [9:0]     ticks,
   input  logic           reset_present,
   output seq_state_type  state_nxt,
   output seq_result_type result
);

   seq_state_type nx;
   logic [5:0]    next_idx;
   logic [2:0]    act_run;
   logic [2:0]    act_new;
   logic          done;
   logic          rej;

   always_comb begin
      nx       = state_cur;
      next_idx = state_cur.phase + 6'd1;
      act_run  = action_f(state_cur.cmd, next_idx, state_cur.shift[7], state_cur.level);
      act_new  = ACT_END;
      done     = 1'b0;
      rej      = 1'b0;

      // advance the running sequence
      if (state_cur.cmd != CMD_NONE) begin
         if (state_cur.hold > 10'd1) begin
            nx.hold = state_cur.hold - 10'd1;
         end else begin
            if (state_cur.cmd == CMD_PROBE && next_idx == ACK_SAMPLE_IDX) begin
               nx.ack_seen = ~sda_sample;
            end
            if (act_run == ACT_END) begin
               done     = (state_cur.cmd == CMD_PROBE);
               nx.cmd   = CMD_NONE;
               nx.phase = '0;
               nx.hold  = '0;
            end else begin
               nx = apply_f(nx, state_cur.cmd, next_idx, act_run, ticks);
            end
         end
      end

      // decode the new command
      if (opcode != OP_TICK) begin
         if (opcode > OP_RESET || nx.cmd != CMD_NONE) begin
            rej = 1'b1;
         end else if (opcode == OP_RESET) begin
            if (reset_present) nx.rst_drv = data_byte[0];
         end else begin
            nx.cmd   = cmd_type'(opcode[2:0]);
            nx.level = data_byte[0];
            if (nx.cmd == CMD_PROBE) nx.shift = {data_byte[6:0], 1'b0};
            else nx.shift = data_byte;
            act_new = action_f(nx.cmd, 6'd0, nx.shift[7], nx.level);
            nx      = apply_f(nx, nx.cmd, 6'd0, act_new, ticks);
         end
      end
   end

   assign state_nxt = nx;

   // result fields
   always_comb begin
      result.scl_level   = nx.clk_drv;
      result.sda_level   = nx.dat_drv;
      result.reset_level = nx.rst_drv;
      result.busy        = (nx.cmd != CMD_NONE);
      result.probe_done  = done;
      result.probe_ack   = nx.ack_seen;
      result.rejected    = rej;
   end

endmodule

>>> hw/rtl/i2cws_checker.sv
// ----------------------------------------------------------------------------
// i2cws_checker
// Port-level checks of the sequencer handshake, bound to the top level.
// ----------------------------------------------------------------------------
module i2cws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // reset leaves no response pending and the request side open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response pending or request blocked after reset");

   // an empty response register never blocks requests
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // a stalled response transaction keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind i2c_master_write_sequencer_unit i2cws_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
